/* rtl/mbrtu_pkg.sv */
// Shared constants, types and CRC helper functions for the Modbus RTU response deframer.
`timescale 1ns / 1ps

package mbrtu_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 52;
  // Address, function code, length byte and two CRC bytes.
  localparam int unsigned FRAME_OVERHEAD    = 5;
  localparam int unsigned IDX_W             = 6;
  localparam int unsigned CFG_IDX_W         = 2;
  localparam int unsigned CFG_DATA_W        = 8;

  localparam logic [7:0]  DEV_ADDR_RST  = 8'h01;
  localparam logic [7:0]  FUNC_CODE_RST = 8'h03;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  // Bit-reversed form of the polynomial 0x8005.
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDRESS = 2'd0,
    REG_FUNCTION_CODE  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] function_code;
  } hdr_cfg_t;

  // Eight shift/xor steps of the reflected CRC, no data byte mixed in.
  function automatic logic [15:0] crc_byte_shift(input logic [15:0] v);
    logic [15:0] c;
    c = v;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Applies the byte step n times; used only on constants at elaboration.
  function automatic logic [15:0] crc_advance(input logic [15:0] v, input int unsigned n);
    logic [15:0] c;
    c = v;
    for (int unsigned i = 0; i < n; i++) begin
      c = crc_byte_shift(c);
    end
    return c;
  endfunction

  // Columns of the linear map that removes a byte leaving the CRC span.
  function automatic logic [7:0][15:0] crc_drop_cols(input int unsigned n);
    logic [7:0][15:0] cols;
    for (int b = 0; b < 8; b++) begin
      cols[b] = crc_advance(16'(1) << b, n);
    end
    return cols;
  endfunction

endpackage

/* rtl/modbus_rtu_response_deframer.sv */
// Top level of the Modbus RTU read-response deframer with CRC-16 check.
//
// Usage: received serial bytes enter on in_valid/in_rx_byte, one transaction
// per byte, taken at an edge where in_valid is high and in_stall is low.
// The last PAYLOAD_BYTES + 5 bytes form a sliding window; when it holds a
// frame with the configured address and function code, a length byte equal
// to PAYLOAD_BYTES and a matching CRC-16 (low byte first), the payload bytes
// leave on out_valid/out_payload_byte with out_byte_index and out_last_byte.
// The window then empties, so overlapping frames are never reported.
// Throughput: one input byte per cycle while in_stall is low; the window,
// CRC update and check complete in the cycle the byte is taken. A frame's
// payload bytes pass a queue slot and the output register, one per cycle while
// out_stall is low. Frames wait in a two-entry queue; in_stall rises only
// when both entries hold undelivered frames, which with a free-running
// output never happens. A stalled output holds its transaction unchanged.
// Reset (rst_n low, synchronous) empties the window and the queue and sets
// the address to 1 and the function code to 3; cfg_we writes them any time.

`timescale 1ns / 1ps

module modbus_rtu_response_deframer #(
  parameter int unsigned PAYLOAD_BYTES = mbrtu_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mbrtu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbrtu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_payload_byte,
  output logic [mbrtu_pkg::IDX_W-1:0]          out_byte_index,
  output logic                                 out_last_byte
);

  mbrtu_pkg::hdr_cfg_t           hdr_cfg_r;
  mbrtu_pkg::hdr_cfg_t           hdr_cfg_nxt;
  logic                          q_full;
  logic                          push;
  logic [PAYLOAD_BYTES-1:0][7:0] push_data;

  always_comb begin
    hdr_cfg_nxt = hdr_cfg_r;
    if (cfg_we) begin
      case (mbrtu_pkg::cfg_reg_t'(cfg_index))
        mbrtu_pkg::REG_DEVICE_ADDRESS: hdr_cfg_nxt.device_address = cfg_wdata[7:0];
        mbrtu_pkg::REG_FUNCTION_CODE:  hdr_cfg_nxt.function_code  = cfg_wdata[7:0];
        default:                       hdr_cfg_nxt = hdr_cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cfg_r.device_address <= mbrtu_pkg::DEV_ADDR_RST;
      hdr_cfg_r.function_code  <= mbrtu_pkg::FUNC_CODE_RST;
    end else begin
      hdr_cfg_r <= hdr_cfg_nxt;
    end
  end

  mbrtu_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .hdr_cfg    (hdr_cfg_r),
    .push       (push),
    .push_data  (push_data)
  );

  mbrtu_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .push_data        (push_data),
    .q_full           (q_full),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last_byte    (out_last_byte)
  );

endmodule

/* rtl/mbrtu_front.sv */
// Front end: byte window, sliding CRC and frame validation.
`timescale 1ns / 1ps

module mbrtu_front #(
  parameter int unsigned PAYLOAD_BYTES = mbrtu_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [7:0]                     in_rx_byte,
  output logic                           in_stall,
  input  logic                           q_full,
  input  mbrtu_pkg::hdr_cfg_t            hdr_cfg,
  output logic                           push,
  output logic [PAYLOAD_BYTES-1:0][7:0]  push_data
);

  localparam int unsigned FRAME_LEN = PAYLOAD_BYTES + mbrtu_pkg::FRAME_OVERHEAD;
  localparam int unsigned SPAN      = FRAME_LEN - 2;
  localparam int unsigned FILL_W    = $clog2(FRAME_LEN + 1);
  localparam logic [15:0] CRC_K     = mbrtu_pkg::crc_advance(mbrtu_pkg::CRC_INIT, SPAN);
  localparam logic [7:0][15:0] DROP_COLS = mbrtu_pkg::crc_drop_cols(SPAN + 1);

  logic [7:0]        win_r     [FRAME_LEN];
  logic [7:0]        win_shift [FRAME_LEN];
  logic [7:0]        win_nxt   [FRAME_LEN];
  logic [15:0]       crc_r;
  logic [15:0]       crc_nxt;
  logic [15:0]       crc_slid;
  logic [15:0]       crc_drop;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] fill_inc;
  logic              take;
  logic              hdr_ok;
  logic              crc_ok;
  logic              frame_ok;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // The running value is a zero-init CRC over the span; the init term is a constant.
  always_comb begin
    crc_drop = '0;
    for (int b = 0; b < 8; b++) begin
      if (win_r[0][b]) begin
        crc_drop = crc_drop ^ DROP_COLS[b];
      end
    end
    crc_slid = mbrtu_pkg::crc_byte_shift(crc_r ^ {8'h00, win_r[SPAN]}) ^ crc_drop;
  end

  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      win_shift[i] = win_r[i+1];
    end
    win_shift[FRAME_LEN-1] = in_rx_byte;
  end

  assign fill_inc = (fill_r == FILL_W'(FRAME_LEN)) ? fill_r : fill_r + FILL_W'(1);

  assign hdr_ok = (win_shift[0] == hdr_cfg.device_address) &&
                  (win_shift[1] == hdr_cfg.function_code) &&
                  (win_shift[2] == 8'(PAYLOAD_BYTES));
  assign crc_ok = (crc_slid ^ CRC_K) == {win_shift[FRAME_LEN-1], win_shift[FRAME_LEN-2]};

  assign frame_ok = (fill_inc == FILL_W'(FRAME_LEN)) && hdr_ok && crc_ok;
  assign push     = take && frame_ok;

  always_comb begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      push_data[i] = win_shift[3+i];
    end
  end

  // An accepted frame empties the window so none of its bytes is reused.
  always_comb begin
    win_nxt  = win_r;
    crc_nxt  = crc_r;
    fill_nxt = fill_r;
    if (take) begin
      if (frame_ok) begin
        for (int i = 0; i < FRAME_LEN; i++) begin
          win_nxt[i] = 8'h00;
        end
        crc_nxt  = '0;
        fill_nxt = '0;
      end else begin
        win_nxt  = win_shift;
        crc_nxt  = crc_slid;
        fill_nxt = fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        win_r[i] <= 8'h00;
      end
      crc_r  <= '0;
      fill_r <= '0;
    end else begin
      win_r  <= win_nxt;
      crc_r  <= crc_nxt;
      fill_r <= fill_nxt;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(FRAME_LEN))
    else $error("fill count beyond frame length");

  a_push_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (fill_r == '0) && (crc_r == '0))
    else $error("window not emptied after an accepted frame");

endmodule

/* rtl/mbrtu_back.sv */
// Back end: two-entry frame queue fed to the output register one byte per unstalled cycle.
`timescale 1ns / 1ps

module mbrtu_back #(
  parameter int unsigned PAYLOAD_BYTES = mbrtu_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [PAYLOAD_BYTES-1:0][7:0]       push_data,
  output logic                                q_full,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_payload_byte,
  output logic [mbrtu_pkg::IDX_W-1:0]         out_byte_index,
  output logic                                out_last_byte
);

  localparam int unsigned IDX_W = mbrtu_pkg::IDX_W;

  logic [PAYLOAD_BYTES-1:0][7:0] slot_r [2];
  logic [1:0]       slot_vld_r;
  logic [1:0]       slot_vld_nxt;
  logic             hd_r;
  logic             hd_nxt;
  logic             tl_r;
  logic             tl_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_last_r;
  logic             load;
  logic             pop;
  logic             idx_last;

  assign q_full   = slot_vld_r[0] && slot_vld_r[1];
  assign load     = !out_valid_r || !out_stall;
  assign pop      = slot_vld_r[hd_r] && load;
  assign idx_last = (idx_r == IDX_W'(PAYLOAD_BYTES - 1));

  always_comb begin
    slot_vld_nxt  = slot_vld_r;
    hd_nxt        = hd_r;
    tl_nxt        = tl_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = slot_vld_r[hd_r];
    end
    if (pop) begin
      if (idx_last) begin
        slot_vld_nxt[hd_r] = 1'b0;
        hd_nxt             = !hd_r;
        idx_nxt            = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
    if (push) begin
      slot_vld_nxt[tl_r] = 1'b1;
      tl_nxt             = !tl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r  <= '0;
      hd_r        <= 1'b0;
      tl_r        <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_vld_r  <= slot_vld_nxt;
      hd_r        <= hd_nxt;
      tl_r        <= tl_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A push always targets the free slot, so it never meets the slot being drained.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tl_r] <= push_data;
    end
    if (pop) begin
      slot_r[hd_r] <= slot_r[hd_r] >> 8;
      out_byte_r   <= slot_r[hd_r][0];
      out_idx_r    <= idx_r;
      out_last_r   <= idx_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_index   = out_idx_r;
  assign out_last_byte    = out_last_r;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("frame pushed into a full queue");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_byte) |-> (out_byte_index == IDX_W'(PAYLOAD_BYTES - 1)))
    else $error("last byte flag at wrong index");

  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_byte) |=> out_valid)
    else $error("gap inside a frame on the output");

endmodule

/* tb/modbus_rtu_response_deframer_checker.sv */
// Checker that predicts and compares the payload transactions of the Modbus RTU deframer.
`timescale 1ns / 1ps

module modbus_rtu_response_deframer_checker #(
  parameter int unsigned PAYLOAD_BYTES = mbrtu_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mbrtu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbrtu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [7:0]                       out_payload_byte,
  input  logic [mbrtu_pkg::IDX_W-1:0]      out_byte_index,
  input  logic                             out_last_byte,
  output int                               fail_count,
  output int                               pending
);

  localparam int unsigned FRAME_LEN  = PAYLOAD_BYTES + mbrtu_pkg::FRAME_OVERHEAD;
  localparam int unsigned IDX_W      = mbrtu_pkg::IDX_W;
  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } payload_beat_t;

  logic [7:0]    dev_addr;
  logic [7:0]    func_code;
  logic [7:0]    window [FRAME_LEN];
  int unsigned   fill;
  payload_beat_t beat_q [$];
  int            mismatches = 0;

  // CRC-16/MODBUS over everything in the window except the two CRC bytes.
  function automatic logic [15:0] window_crc();
    logic [15:0] crc;
    crc = mbrtu_pkg::CRC_INIT;
    for (int i = 0; i < FRAME_LEN - 2; i++) begin
      crc ^= {8'h00, window[i]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ mbrtu_pkg::CRC_POLY_REFL) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  task automatic take_byte(input logic [7:0] rx);
    payload_beat_t beat;
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      window[i] = window[i + 1];
    end
    window[FRAME_LEN - 1] = rx;
    if (fill < FRAME_LEN) begin
      fill++;
    end
    if (fill == FRAME_LEN && window[0] == dev_addr && window[1] == func_code &&
        window[2] == 8'(PAYLOAD_BYTES) &&
        window_crc() == {window[FRAME_LEN - 1], window[FRAME_LEN - 2]}) begin
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        beat.data = window[3 + i];
        beat.idx  = IDX_W'(i);
        beat.last = (i == PAYLOAD_BYTES - 1);
        beat_q.push_back(beat);
      end
      // The accepted bytes must never take part in a later frame.
      fill = 0;
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: %s", $realtime, what);
    end
  endtask

  task automatic check_beat();
    payload_beat_t want;
    if (beat_q.size() == 0) begin
      note_mismatch($sformatf("unexpected payload byte %02h index %0d last %b",
                              out_payload_byte, out_byte_index, out_last_byte));
    end else begin
      want = beat_q.pop_front();
      if (want.data !== out_payload_byte || want.idx !== out_byte_index ||
          want.last !== out_last_byte) begin
        note_mismatch($sformatf({"payload mismatch: expected byte %02h index %0d last %b, ",
                                 "got byte %02h index %0d last %b"},
                                want.data, want.idx, want.last,
                                out_payload_byte, out_byte_index, out_last_byte));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dev_addr  = mbrtu_pkg::DEV_ADDR_RST;
      func_code = mbrtu_pkg::FUNC_CODE_RST;
      fill      = 0;
      for (int i = 0; i < FRAME_LEN; i++) begin
        window[i] = 8'h00;
      end
      beat_q.delete();
    end else begin
      if (cfg_we) begin
        case (mbrtu_pkg::cfg_reg_t'(cfg_index))
          mbrtu_pkg::REG_DEVICE_ADDRESS: dev_addr = cfg_wdata;
          mbrtu_pkg::REG_FUNCTION_CODE:  func_code = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        take_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) begin
        check_beat();
      end
    end
    pending    <= beat_q.size();
    fail_count <= mismatches;
  end

endmodule

/* tb/tb_modbus_rtu_response_deframer.sv */
// Stimulus, clock, reset and verdict for the Modbus RTU response deframer.
`timescale 1ns / 1ps

module tb_modbus_rtu_response_deframer;

  localparam int unsigned PAYLOAD_BYTES = mbrtu_pkg::PAYLOAD_BYTES_DEF;
  localparam int unsigned FRAME_LEN     = PAYLOAD_BYTES + mbrtu_pkg::FRAME_OVERHEAD;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned OVERLAP_TRIES = 8192;
  localparam int unsigned MAX_BURST     = 3;

  localparam logic [mbrtu_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [mbrtu_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  typedef enum int {
    DAMAGE_NONE,
    DAMAGE_ADDR,
    DAMAGE_FUNC,
    DAMAGE_LEN,
    DAMAGE_PAYLOAD,
    DAMAGE_CRC_LO,
    DAMAGE_CRC_HI
  } damage_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } payload_fill_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [mbrtu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mbrtu_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       in_rx_byte = 8'h00;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [7:0]                       out_payload_byte;
  logic [mbrtu_pkg::IDX_W-1:0]      out_byte_index;
  logic                             out_last_byte;

  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  cur_addr = mbrtu_pkg::DEV_ADDR_RST;
  logic [7:0]  cur_func = mbrtu_pkg::FUNC_CODE_RST;
  logic [7:0]  frame [FRAME_LEN];

  always #10 clk = ~clk;

  modbus_rtu_response_deframer #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_byte(out_payload_byte),
    .out_byte_index  (out_byte_index),
    .out_last_byte   (out_last_byte)
  );

  modbus_rtu_response_deframer_checker #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_byte(out_payload_byte),
    .out_byte_index  (out_byte_index),
    .out_last_byte   (out_last_byte),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && (int'($urandom_range(0, 99)) < recv_stall_pct);
  end

  // Any cycle that moves a transaction on either channel resets the watchdog.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // CRC over FRAME_LEN - 2 bytes of the frame buffer, starting at first.
  function automatic logic [15:0] frame_crc(input int unsigned first);
    logic [15:0] crc;
    crc = mbrtu_pkg::CRC_INIT;
    for (int unsigned i = first; i < first + FRAME_LEN - 2; i++) begin
      crc ^= {8'h00, frame[i]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ mbrtu_pkg::CRC_POLY_REFL) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  task automatic send_byte(input logic [7:0] rx);
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < FRAME_LEN; i++) begin
      send_byte(frame[i]);
    end
  endtask

  task automatic fill_payload(input payload_fill_t fill);
    for (int i = 3; i < FRAME_LEN - 2; i++) begin
      case (fill)
        FILL_ZERO: frame[i] = 8'h00;
        FILL_ONES: frame[i] = 8'hFF;
        default:   frame[i] = 8'($urandom);
      endcase
    end
  endtask

  // Writes header and CRC around the current payload, then breaks one field unless DAMAGE_NONE.
  task automatic seal_frame(input damage_t damage);
    logic [15:0] crc;
    logic [7:0]  flip;
    frame[0] = cur_addr;
    frame[1] = cur_func;
    frame[2] = 8'(PAYLOAD_BYTES);
    crc = frame_crc(0);
    frame[FRAME_LEN - 2] = crc[7:0];
    frame[FRAME_LEN - 1] = crc[15:8];
    flip = 8'h01 << $urandom_range(0, 7);
    case (damage)
      DAMAGE_ADDR:    frame[0] ^= flip;
      DAMAGE_FUNC:    frame[1] ^= flip;
      DAMAGE_LEN:     frame[2] ^= flip;
      DAMAGE_PAYLOAD: frame[$urandom_range(3, FRAME_LEN - 3)] ^= flip;
      DAMAGE_CRC_LO:  frame[FRAME_LEN - 2] ^= flip;
      DAMAGE_CRC_HI:  frame[FRAME_LEN - 1] ^= flip;
      default: ;
    endcase
  endtask

  task automatic send_good(input payload_fill_t fill);
    fill_payload(fill);
    seal_frame(DAMAGE_NONE);
    send_frame();
  endtask

  task automatic write_cfg(input logic [mbrtu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      mbrtu_pkg::REG_DEVICE_ADDRESS: cur_addr = value;
      mbrtu_pkg::REG_FUNCTION_CODE:  cur_func = value;
      default: ;
    endcase
  endtask

  // Waits for every predicted payload byte to leave the block.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // With address, function code and length all equal to the length byte, a
  // frame is searched whose window shifted by one byte also checks out once
  // one more byte arrives. That second frame overlaps the first and must not
  // be reported.
  task automatic send_overlap_pair();
    logic [15:0] crc;
    logic [15:0] shifted;
    int unsigned tries;
    frame[3] = 8'(PAYLOAD_BYTES);
    tries = 0;
    do begin
      for (int i = 4; i < FRAME_LEN - 2; i++) begin
        frame[i] = 8'($urandom);
      end
      frame[0] = cur_addr;
      frame[1] = cur_func;
      frame[2] = 8'(PAYLOAD_BYTES);
      crc = frame_crc(0);
      frame[FRAME_LEN - 2] = crc[7:0];
      frame[FRAME_LEN - 1] = crc[15:8];
      shifted = frame_crc(1);
      tries++;
    end while (shifted[7:0] != frame[FRAME_LEN - 1] && tries < OVERLAP_TRIES);
    send_frame();
    send_byte(shifted[15:8]);
  endtask

  // A few stray bytes ahead of a frame force the window to resynchronize.
  task automatic random_phase(input logic [7:0] addr, input logic [7:0] func,
                              input int idle_pct, input int stall_pct,
                              input payload_fill_t fill);
    int unsigned count;
    settle();
    write_cfg(mbrtu_pkg::REG_DEVICE_ADDRESS, addr);
    write_cfg(mbrtu_pkg::REG_FUNCTION_CODE, func);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    count = $urandom_range(1, MAX_BURST);
    repeat (count) send_byte(8'($urandom));
    send_good(fill);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, no idling: a frame with one broken field, then an
    // intact one; the first window also covers the bytes taken before it
    // is full.
    fill_payload(FILL_RANDOM);
    seal_frame(damage_t'($urandom_range(DAMAGE_ADDR, DAMAGE_CRC_HI)));
    send_frame();
    send_good(FILL_RANDOM);

    // Writes to unmapped indexes must leave the header settings alone.
    settle();
    write_cfg(mbrtu_pkg::REG_DEVICE_ADDRESS, 8'(PAYLOAD_BYTES));
    write_cfg(mbrtu_pkg::REG_FUNCTION_CODE, 8'(PAYLOAD_BYTES));
    write_cfg(REG_UNMAPPED_LO, 8'h00);
    write_cfg(REG_UNMAPPED_HI, 8'hFF);
    send_overlap_pair();

    random_phase(8'hFF, 8'hFF, 52, 0, FILL_ZERO);
    random_phase(8'($urandom), 8'($urandom), 0, 52, FILL_ONES);
    random_phase(8'($urandom), 8'($urandom), 14, 14, FILL_RANDOM);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending != 0) begin
      $display("%0d predicted payload bytes never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
